/* rtl/fpha_pkg.sv */
// shared types, constants and helpers of the fit-policy heap allocator
package fpha_pkg;

  localparam int UNIT_BYTES = 16;
  localparam int UNIT_LOG2 = $clog2(UNIT_BYTES);
  localparam int HEAP_UNITS = 65536;

  localparam int DEF_MAX_EXTENTS = 64;
  localparam int DEF_QUICK_LISTS = 4;
  localparam int DEF_QUICK_DEPTH = 64;

  localparam int ADDR_W = 16;
  localparam int SIZE_W = 17;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOMEM    = 2'd1,
    ST_NULL     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_QUICK = 2'd3
  } fit_t;

  typedef enum logic [1:0] {
    REG_FIT   = 2'd0,
    REG_LIMIT = 2'd1,
    REG_GROW  = 2'd2,
    REG_QLOG  = 2'd3
  } reg_idx_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [16:0] LIMIT_RST = 17'd65536;
  localparam logic [16:0] GROW_RST  = 17'd1024;
  localparam logic [4:0]  QLOG_RST  = 5'd3;

  typedef struct packed {
    logic              req_type;
    logic [19:0]       req_bytes;
    logic [ADDR_W-1:0] block_addr;
    logic [SIZE_W-1:0] block_units;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] payload_addr;
    logic [SIZE_W-1:0] granted_units;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } ext_entry_t;

  function automatic logic [SIZE_W-1:0] sat17(input logic [SIZE_W+1:0] v);
    sat17 = (v > {2'b00, SIZE_MAX}) ? SIZE_MAX : v[SIZE_W-1:0];
  endfunction

endpackage

/* rtl/fpha_ram.sv */
// generic single write port ram with registered read
module fpha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/fit_policy_heap_allocator_unit.sv */
// Heap allocator over 16-byte units with first, best, worst and quick fit.
//
// Input channel in_valid/in_stall/in_data carries one request word: allocate
// (req_bytes) or free (block_addr, block_units). Every request gives exactly
// one result word on out_valid/out_stall/out_data, in request order.
// The block works on one request at a time; in_stall is high from the cycle
// after acceptance until the result has been moved to the output register.
// An allocation scans the free-extent table one entry per cycle, and
// shifts the entries above an extent that is used up exactly; a free
// scans up to its insert point and shifts the entries above it.
// Growth adds the free path for the leftover, once for every piece in
// quick mode. The extent ram has a single port pair, so entries are
// read and moved one at a time.
// A finished result waits in the output register while out_stall is high;
// the next request is still taken meanwhile and holds until it drains.
// Reset (rst_n low, synchronous) empties the extent table and quick stacks,
// sets the heap top to zero and loads the register defaults. Configuration
// is written through the cfg_ APB port, registers at byte 0, 4, 8 and 12.
module fit_policy_heap_allocator_unit import fpha_pkg::*; #(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
  parameter int QUICK_LISTS = DEF_QUICK_LISTS,
  parameter int QUICK_DEPTH = DEF_QUICK_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int IW   = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW   = $clog2(MAX_EXTENTS + 1);
  localparam int QIW  = $clog2(QUICK_LISTS + 1);
  localparam int QSW  = (QUICK_LISTS > 1) ? $clog2(QUICK_LISTS) : 1;
  localparam int SDEP = QUICK_LISTS * QUICK_DEPTH;
  localparam int SAW  = (SDEP > 1) ? $clog2(SDEP) : 1;
  localparam int SAW1 = SAW + 1;
  localparam int FW   = $clog2(QUICK_DEPTH + 1);
  localparam int BW   = SIZE_W + UNIT_LOG2;
  localparam logic [SIZE_W-1:0] HEAP_CAP =
    (HEAP_UNITS > 131071) ? SIZE_MAX : SIZE_W'(HEAP_UNITS);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_ALLOC  = 14'b00000000000010,
    S_POP    = 14'b00000000000100,
    S_SCAN   = 14'b00000000001000,
    S_TAKE   = 14'b00000000010000,
    S_GROW   = 14'b00000000100000,
    S_CHOP   = 14'b00000001000000,
    S_FB     = 14'b00000010000000,
    S_INS    = 14'b00000100000000,
    S_MERGE  = 14'b00001000000000,
    S_MOVE   = 14'b00010000000000,
    S_FINAL  = 14'b00100000000000,
    S_FBDONE = 14'b01000000000000,
    S_RESP   = 14'b10000000000000
  } state_t;

  typedef enum logic [1:0] {
    FIN_TAKE   = 2'd0,
    FIN_JOIN   = 2'd1,
    FIN_INSERT = 2'd2
  } fin_t;

  // control state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [SIZE_W-1:0] heap_top_r, heap_top_nxt;
  logic [FW-1:0]     fill_r [QUICK_LISTS];
  logic [FW-1:0]     fill_nxt [QUICK_LISTS];
  logic              chk_v_r, chk_v_nxt;
  logic              mv_wv_r, mv_wv_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        fit_r, fit_nxt;
  logic [SIZE_W-1:0] limit_r, limit_nxt;
  logic [SIZE_W-1:0] grow_r, grow_nxt;
  logic [4:0]        qlog_r, qlog_nxt;

  // working registers
  logic [SIZE_W-1:0] n_r, n_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] res_payload_r, res_payload_nxt;
  logic [SIZE_W-1:0] res_units_r, res_units_nxt;
  logic [CW-1:0]     scan_i_r, scan_i_nxt;
  logic [CW-1:0]     chk_i_r, chk_i_nxt;
  logic              ch_v_r, ch_v_nxt;
  logic [CW-1:0]     ch_i_r, ch_i_nxt;
  logic [ADDR_W-1:0] ch_start_r, ch_start_nxt;
  logic [SIZE_W-1:0] ch_size_r, ch_size_nxt;
  logic [SIZE_W-1:0] left_r, left_nxt;
  logic [SIZE_W-1:0] at_r, at_nxt;
  logic              grow_ctx_r, grow_ctx_nxt;
  logic [SIZE_W-1:0] fb_start_r, fb_start_nxt;
  logic [SIZE_W-1:0] fb_size_r, fb_size_nxt;
  logic [1:0]        fb_st_r, fb_st_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic              found_r, found_nxt;
  logic              prev_v_r, prev_v_nxt;
  logic [ADDR_W-1:0] prev_start_r, prev_start_nxt;
  logic [SIZE_W-1:0] prev_size_r, prev_size_nxt;
  logic [ADDR_W-1:0] next_start_r, next_start_nxt;
  logic [SIZE_W-1:0] next_size_r, next_size_nxt;
  logic              mv_up_r, mv_up_nxt;
  logic [CW-1:0]     mv_src_r, mv_src_nxt;
  logic [CW-1:0]     mv_cnt_r, mv_cnt_nxt;
  logic [CW-1:0]     mv_wa_r, mv_wa_nxt;
  fin_t              fin_r, fin_nxt;
  logic [QIW-1:0]    pop_idx_r, pop_idx_nxt;
  out_word_t         out_data_r, out_data_nxt;

  // ram ports
  logic              ext_we;
  logic [IW-1:0]     ext_waddr, ext_raddr;
  ext_entry_t        ext_wdata, ext_rdata;
  logic              q_we;
  logic [SAW-1:0]    q_waddr, q_raddr;
  logic [ADDR_W-1:0] q_wdata, q_rdata;

  // shared quick-class unit
  logic [BW-1:0]     qb;
  logic [QIW-1:0]    q_idx;
  logic              q_in, q_exact;
  logic [QSW-1:0]    q_sel;
  logic [FW-1:0]     q_fill, q_fillv;
  logic [SAW-1:0]    q_addr;
  logic [SIZE_W-1:0] pop_units;

  logic              cfg_wr;

  fpha_ram #(.WIDTH($bits(ext_entry_t)), .DEPTH(MAX_EXTENTS)) u_ext_ram (
    .clk   (clk),
    .we    (ext_we),
    .waddr (ext_waddr),
    .wdata (ext_wdata),
    .raddr (ext_raddr),
    .rdata (ext_rdata)
  );

  fpha_ram #(.WIDTH(ADDR_W), .DEPTH(SDEP)) u_quick_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // size class of a block: first stack whose size is not below the payload bytes
  always_comb begin
    logic [6:0]    e;
    logic [BW-1:0] pw;
    if (state_r == S_ALLOC) begin
      qb = BW'(n_r - 17'd1) << UNIT_LOG2;
    end else begin
      qb = BW'(fb_size_r - 17'd1) << UNIT_LOG2;
    end
    q_idx = '0;
    for (int i = 0; i < QUICK_LISTS; i++) begin
      e  = 7'(qlog_r) + 7'(i);
      pw = BW'(1) << e;
      if (pw != '0 && pw < qb) begin
        q_idx = QIW'(i + 1);
      end
    end
    q_exact = 1'b0;
    for (int i = 0; i < QUICK_LISTS; i++) begin
      e  = 7'(qlog_r) + 7'(i);
      pw = BW'(1) << e;
      if (QIW'(i) == q_idx && pw != '0 && pw == qb) begin
        q_exact = 1'b1;
      end
    end
    q_in   = q_idx < QIW'(QUICK_LISTS);
    q_sel  = QSW'(q_idx);
    q_fill = fill_r[q_sel];
    q_fillv = (state_r == S_ALLOC) ? q_fill - FW'(1) : q_fill;
    q_addr = SAW'(SAW1'(q_sel) * SAW1'(QUICK_DEPTH) + SAW1'(q_fillv));
  end

  always_comb begin
    logic [6:0] e;
    e = 7'(qlog_r) + 7'(pop_idx_r);
    if (e < 7'(UNIT_LOG2)) begin
      pop_units = 17'd1;
    end else begin
      pop_units = (17'd1 << (e - 7'(UNIT_LOG2))) + 17'd1;
    end
  end

  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    logic [20:0]       nb;
    logic [SIZE_W-1:0] g, lim, piece;
    logic              take, upd, lo, hi;
    ext_entry_t        rd;

    state_nxt       = state_r;
    count_nxt       = count_r;
    heap_top_nxt    = heap_top_r;
    fill_nxt        = fill_r;
    chk_v_nxt       = 1'b0;
    mv_wv_nxt       = 1'b0;
    out_valid_nxt   = out_valid_r;
    fit_nxt         = fit_r;
    limit_nxt       = limit_r;
    grow_nxt        = grow_r;
    qlog_nxt        = qlog_r;
    n_nxt           = n_r;
    st_nxt          = st_r;
    res_status_nxt  = res_status_r;
    res_payload_nxt = res_payload_r;
    res_units_nxt   = res_units_r;
    scan_i_nxt      = scan_i_r;
    chk_i_nxt       = chk_i_r;
    ch_v_nxt        = ch_v_r;
    ch_i_nxt        = ch_i_r;
    ch_start_nxt    = ch_start_r;
    ch_size_nxt     = ch_size_r;
    left_nxt        = left_r;
    at_nxt          = at_r;
    grow_ctx_nxt    = grow_ctx_r;
    fb_start_nxt    = fb_start_r;
    fb_size_nxt     = fb_size_r;
    fb_st_nxt       = fb_st_r;
    pos_nxt         = pos_r;
    found_nxt       = found_r;
    prev_v_nxt      = prev_v_r;
    prev_start_nxt  = prev_start_r;
    prev_size_nxt   = prev_size_r;
    next_start_nxt  = next_start_r;
    next_size_nxt   = next_size_r;
    mv_up_nxt       = mv_up_r;
    mv_src_nxt      = mv_src_r;
    mv_cnt_nxt      = mv_cnt_r;
    mv_wa_nxt       = mv_wa_r;
    fin_nxt         = fin_r;
    pop_idx_nxt     = pop_idx_r;
    out_data_nxt    = out_data_r;

    ext_we    = 1'b0;
    ext_waddr = '0;
    ext_wdata = '0;
    ext_raddr = '0;
    q_we      = 1'b0;
    q_waddr   = q_addr;
    q_wdata   = fb_start_r[ADDR_W-1:0];
    q_raddr   = q_addr;

    nb    = 21'(in_data.req_bytes) + 21'(UNIT_BYTES - 1);
    g     = (n_r < grow_r) ? grow_r : n_r;
    lim   = (limit_r < HEAP_CAP) ? limit_r : HEAP_CAP;
    piece = (fit_r == FIT_QUICK && n_r < left_r) ? n_r : left_r;
    take  = 1'b0;
    upd   = 1'b0;
    rd    = ext_rdata;
    lo    = prev_v_r &&
            ({2'b00, prev_start_r} + 18'(prev_size_r)) == 18'(fb_start_r);
    hi    = found_r &&
            (18'(fb_start_r) + 18'(fb_size_r)) == 18'(next_start_r);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_paddr[3:2]))
        REG_FIT:   fit_nxt   = cfg_pwdata[1:0];
        REG_LIMIT: limit_nxt = cfg_pwdata[SIZE_W-1:0];
        REG_GROW:  grow_nxt  = cfg_pwdata[SIZE_W-1:0];
        REG_QLOG:  qlog_nxt  = cfg_pwdata[4:0];
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_payload_nxt = '0;
          res_units_nxt   = '0;
          if (in_data.req_type == REQ_FREE) begin
            if (in_data.block_addr == '0 || in_data.block_units == '0) begin
              res_status_nxt = ST_NULL;
              state_nxt      = S_RESP;
            end else begin
              fb_start_nxt = SIZE_W'(in_data.block_addr - 16'd1);
              fb_size_nxt  = in_data.block_units;
              grow_ctx_nxt = 1'b0;
              state_nxt    = S_FB;
            end
          end else if (in_data.req_bytes == '0) begin
            res_status_nxt = ST_NULL;
            state_nxt      = S_RESP;
          end else begin
            n_nxt     = SIZE_W'(nb >> UNIT_LOG2) + 17'd1;
            state_nxt = S_ALLOC;
          end
        end
      end

      S_ALLOC: begin
        // quick stacks first, pop reads the top word
        if (fit_r == FIT_QUICK && q_in && q_fill != '0) begin
          fill_nxt[q_sel] = q_fill - FW'(1);
          pop_idx_nxt     = q_idx;
          state_nxt       = S_POP;
        end else begin
          scan_i_nxt = '0;
          ch_v_nxt   = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_POP: begin
        res_status_nxt  = ST_OK;
        res_payload_nxt = q_rdata + 16'd1;
        res_units_nxt   = pop_units;
        state_nxt       = S_RESP;
      end

      S_SCAN: begin
        ext_raddr = scan_i_r[IW-1:0];
        if (chk_v_r && rd.size >= n_r) begin
          if (rd.size == n_r || fit_r == FIT_FIRST || fit_r == FIT_QUICK) begin
            take = 1'b1;
          end else if (!ch_v_r || (fit_r == FIT_BEST && rd.size < ch_size_r) ||
                       (fit_r == FIT_WORST && rd.size > ch_size_r)) begin
            upd = 1'b1;
          end
        end
        if (take || upd) begin
          ch_v_nxt     = 1'b1;
          ch_i_nxt     = chk_i_r;
          ch_start_nxt = rd.start;
          ch_size_nxt  = rd.size;
        end
        if (take) begin
          state_nxt = S_TAKE;
        end else if (scan_i_r < count_r) begin
          chk_v_nxt  = 1'b1;
          chk_i_nxt  = scan_i_r;
          scan_i_nxt = scan_i_r + CW'(1);
        end else if (!chk_v_r) begin
          state_nxt = ch_v_r ? S_TAKE : S_GROW;
        end
      end

      S_TAKE: begin
        res_status_nxt = ST_OK;
        res_units_nxt  = n_r;
        if (ch_size_r == n_r) begin
          res_payload_nxt = ch_start_r + 16'd1;
          mv_up_nxt       = 1'b0;
          mv_src_nxt      = ch_i_r + CW'(1);
          mv_cnt_nxt      = count_r - ch_i_r - CW'(1);
          fin_nxt         = FIN_TAKE;
          state_nxt       = S_MOVE;
        end else begin
          ext_we          = 1'b1;
          ext_waddr       = ch_i_r[IW-1:0];
          ext_wdata.start = ch_start_r;
          ext_wdata.size  = ch_size_r - n_r;
          res_payload_nxt = 16'(17'(ch_start_r) + ch_size_r - n_r) + 16'd1;
          state_nxt       = S_RESP;
        end
      end

      S_GROW: begin
        if (heap_top_r > lim || g > lim - heap_top_r) begin
          res_status_nxt  = ST_NOMEM;
          res_payload_nxt = '0;
          res_units_nxt   = '0;
          state_nxt       = S_RESP;
        end else begin
          res_payload_nxt = heap_top_r[ADDR_W-1:0] + 16'd1;
          res_units_nxt   = n_r;
          heap_top_nxt    = heap_top_r + g;
          left_nxt        = g - n_r;
          at_nxt          = heap_top_r + n_r;
          st_nxt          = ST_OK;
          grow_ctx_nxt    = 1'b1;
          state_nxt       = S_CHOP;
        end
      end

      S_CHOP: begin
        // leftover goes back as one piece, or request-sized pieces in quick mode
        if (left_r == '0) begin
          res_status_nxt = st_r;
          state_nxt      = S_RESP;
        end else begin
          fb_start_nxt = at_r;
          fb_size_nxt  = piece;
          at_nxt       = at_r + piece;
          left_nxt     = left_r - piece;
          state_nxt    = S_FB;
        end
      end

      S_FB: begin
        if (fit_r == FIT_QUICK && q_in && q_exact) begin
          if (q_fill >= FW'(QUICK_DEPTH)) begin
            fb_st_nxt = ST_OVERFLOW;
          end else begin
            q_we            = 1'b1;
            fill_nxt[q_sel] = q_fill + FW'(1);
            fb_st_nxt       = ST_OK;
          end
          state_nxt = S_FBDONE;
        end else begin
          scan_i_nxt = '0;
          found_nxt  = 1'b0;
          prev_v_nxt = 1'b0;
          pos_nxt    = count_r;
          state_nxt  = S_INS;
        end
      end

      S_INS: begin
        ext_raddr = scan_i_r[IW-1:0];
        if (chk_v_r) begin
          if (17'(rd.start) > fb_start_r) begin
            take = 1'b1;
          end else begin
            prev_v_nxt     = 1'b1;
            prev_start_nxt = rd.start;
            prev_size_nxt  = rd.size;
          end
        end
        if (take) begin
          found_nxt      = 1'b1;
          pos_nxt        = chk_i_r;
          next_start_nxt = rd.start;
          next_size_nxt  = rd.size;
          state_nxt      = S_MERGE;
        end else if (scan_i_r < count_r) begin
          chk_v_nxt  = 1'b1;
          chk_i_nxt  = scan_i_r;
          scan_i_nxt = scan_i_r + CW'(1);
        end else if (!chk_v_r) begin
          state_nxt = S_MERGE;
        end
      end

      S_MERGE: begin
        fb_st_nxt = ST_OK;
        state_nxt = S_FBDONE;
        if (lo && hi) begin
          ext_we          = 1'b1;
          ext_waddr       = IW'(pos_r - CW'(1));
          ext_wdata.start = prev_start_r;
          ext_wdata.size  = sat17(19'(prev_size_r) + 19'(fb_size_r) + 19'(next_size_r));
          mv_up_nxt       = 1'b0;
          mv_src_nxt      = pos_r + CW'(1);
          mv_cnt_nxt      = count_r - pos_r - CW'(1);
          fin_nxt         = FIN_JOIN;
          state_nxt       = S_MOVE;
        end else if (lo) begin
          ext_we          = 1'b1;
          ext_waddr       = IW'(pos_r - CW'(1));
          ext_wdata.start = prev_start_r;
          ext_wdata.size  = sat17(19'(prev_size_r) + 19'(fb_size_r));
        end else if (hi) begin
          ext_we          = 1'b1;
          ext_waddr       = pos_r[IW-1:0];
          ext_wdata.start = fb_start_r[ADDR_W-1:0];
          ext_wdata.size  = sat17(19'(fb_size_r) + 19'(next_size_r));
        end else if (count_r >= CW'(MAX_EXTENTS)) begin
          fb_st_nxt = ST_OVERFLOW;
        end else begin
          mv_up_nxt  = 1'b1;
          mv_src_nxt = count_r - CW'(1);
          mv_cnt_nxt = count_r - pos_r;
          fin_nxt    = FIN_INSERT;
          state_nxt  = S_MOVE;
        end
      end

      S_MOVE: begin
        // read one entry per cycle, write it one place over the next cycle
        ext_raddr = mv_src_r[IW-1:0];
        ext_we    = mv_wv_r;
        ext_waddr = mv_wa_r[IW-1:0];
        ext_wdata = ext_rdata;
        if (mv_cnt_r != '0) begin
          mv_wv_nxt  = 1'b1;
          mv_wa_nxt  = mv_up_r ? mv_src_r + CW'(1) : mv_src_r - CW'(1);
          mv_src_nxt = mv_up_r ? mv_src_r - CW'(1) : mv_src_r + CW'(1);
          mv_cnt_nxt = mv_cnt_r - CW'(1);
        end else if (!mv_wv_r) begin
          state_nxt = S_FINAL;
        end
      end

      S_FINAL: begin
        unique case (fin_r)
          FIN_TAKE: begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_RESP;
          end
          FIN_JOIN: begin
            count_nxt = count_r - CW'(1);
            fb_st_nxt = ST_OK;
            state_nxt = S_FBDONE;
          end
          FIN_INSERT: begin
            ext_we          = 1'b1;
            ext_waddr       = pos_r[IW-1:0];
            ext_wdata.start = fb_start_r[ADDR_W-1:0];
            ext_wdata.size  = fb_size_r;
            count_nxt       = count_r + CW'(1);
            fb_st_nxt       = ST_OK;
            state_nxt       = S_FBDONE;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      S_FBDONE: begin
        if (grow_ctx_r) begin
          if (fb_st_r == ST_OVERFLOW) begin
            st_nxt = ST_OVERFLOW;
          end
          state_nxt = S_CHOP;
        end else begin
          res_status_nxt = fb_st_r;
          state_nxt      = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = res_status_r;
          out_data_nxt.payload_addr  = res_payload_r;
          out_data_nxt.granted_units = res_units_r;
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      heap_top_r  <= '0;
      for (int i = 0; i < QUICK_LISTS; i++) begin
        fill_r[i] <= '0;
      end
      chk_v_r     <= 1'b0;
      mv_wv_r     <= 1'b0;
      out_valid_r <= 1'b0;
      fit_r       <= FIT_FIRST;
      limit_r     <= LIMIT_RST;
      grow_r      <= GROW_RST;
      qlog_r      <= QLOG_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      heap_top_r  <= heap_top_nxt;
      fill_r      <= fill_nxt;
      chk_v_r     <= chk_v_nxt;
      mv_wv_r     <= mv_wv_nxt;
      out_valid_r <= out_valid_nxt;
      fit_r       <= fit_nxt;
      limit_r     <= limit_nxt;
      grow_r      <= grow_nxt;
      qlog_r      <= qlog_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r           <= n_nxt;
    st_r          <= st_nxt;
    res_status_r  <= res_status_nxt;
    res_payload_r <= res_payload_nxt;
    res_units_r   <= res_units_nxt;
    scan_i_r      <= scan_i_nxt;
    chk_i_r       <= chk_i_nxt;
    ch_v_r        <= ch_v_nxt;
    ch_i_r        <= ch_i_nxt;
    ch_start_r    <= ch_start_nxt;
    ch_size_r     <= ch_size_nxt;
    left_r        <= left_nxt;
    at_r          <= at_nxt;
    grow_ctx_r    <= grow_ctx_nxt;
    fb_start_r    <= fb_start_nxt;
    fb_size_r     <= fb_size_nxt;
    fb_st_r       <= fb_st_nxt;
    pos_r         <= pos_nxt;
    found_r       <= found_nxt;
    prev_v_r      <= prev_v_nxt;
    prev_start_r  <= prev_start_nxt;
    prev_size_r   <= prev_size_nxt;
    next_start_r  <= next_start_nxt;
    next_size_r   <= next_size_nxt;
    mv_up_r       <= mv_up_nxt;
    mv_src_r      <= mv_src_nxt;
    mv_cnt_r      <= mv_cnt_nxt;
    mv_wa_r       <= mv_wa_nxt;
    fin_r         <= fin_nxt;
    pop_idx_r     <= pop_idx_nxt;
    out_data_r    <= out_data_nxt;
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[3:2]))
      REG_FIT:   cfg_prdata = CFG_DW'(fit_r);
      REG_LIMIT: cfg_prdata = CFG_DW'(limit_r);
      REG_GROW:  cfg_prdata = CFG_DW'(grow_r);
      REG_QLOG:  cfg_prdata = CFG_DW'(qlog_r);
    endcase
  end

  assign cfg_pready = 1'b1;
  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

endmodule
